### hw/rtl/hpma_pkg.sv
// Shared types and constants for the host port memory access block.
// Used by every module under hw/rtl; depends on nothing.
package hpma_pkg;

    localparam int COEF_DEPTH  = 1024;
    localparam int PROG_DEPTH  = 1024;
    localparam int SETUP_COUNT = 16;

    localparam int COEF_AW  = (COEF_DEPTH  > 1) ? $clog2(COEF_DEPTH)  : 1;
    localparam int PROG_AW  = (PROG_DEPTH  > 1) ? $clog2(PROG_DEPTH)  : 1;
    localparam int SETUP_AW = (SETUP_COUNT > 1) ? $clog2(SETUP_COUNT) : 1;

    localparam int ADDR_W = 14;

    localparam logic [ADDR_W-1:0] ADDR_SETUP   = 14'h0800;
    localparam logic [ADDR_W-1:0] ADDR_PROG    = 14'h1000;
    localparam logic [ADDR_W-1:0] ADDR_LD_COEF = 14'h2000;
    localparam logic [ADDR_W-1:0] ADDR_LD_ONES = 14'h2800;
    localparam logic [ADDR_W-1:0] ADDR_LD_PROG = 14'h3000;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef struct packed {
        logic                is_read;
        logic                wr_coef;
        logic                wr_setup;
        logic                wr_prog;
        logic                ld_coef;
        logic                ld_ones;
        logic                ld_prog;
        logic                in_range;
        logic [COEF_AW-1:0]  coef_addr;
        logic [PROG_AW-1:0]  prog_addr;
        logic [SETUP_AW-1:0] setup_addr;
        logic [1:0]          lane;
        logic [7:0]          data;
    } t_acc;

endpackage

### hw/rtl/hpma_decode.sv
// Address swizzle and region decode for one host access.
// Depends on hpma_pkg.
module hpma_decode (
    input  logic                        i_rev,
    input  logic                        i_func,
    input  logic [hpma_pkg::ADDR_W-1:0] i_address,
    input  logic [7:0]                  i_data,
    output hpma_pkg::t_acc              o_acc
);
    import hpma_pkg::*;

    logic [ADDR_W-1:0] a;
    logic [9:0]        coef_idx;
    logic [9:0]        prog_idx;
    logic [3:0]        setup_idx;
    logic              coef_ok;
    logic              prog_ok;
    logic              setup_ok;
    logic              wr;

    always_comb begin
        a         = i_rev ? {i_address[ADDR_W-1:2], ~i_address[1:0]} : i_address;
        coef_idx  = a[10:1];
        prog_idx  = a[11:2];
        setup_idx = a[5:2];
        coef_ok   = {1'b0, coef_idx} < 11'(COEF_DEPTH);
        prog_ok   = {1'b0, prog_idx} < 11'(PROG_DEPTH);
        setup_ok  = {1'b0, setup_idx} < 5'(SETUP_COUNT);
        wr        = (i_func == FUNC_WRITE);

        o_acc            = '0;
        o_acc.is_read    = (i_func == FUNC_READ);
        o_acc.coef_addr  = coef_idx[COEF_AW-1:0];
        o_acc.prog_addr  = prog_idx[PROG_AW-1:0];
        o_acc.setup_addr = setup_idx[SETUP_AW-1:0];
        o_acc.lane       = a[1:0];
        o_acc.data       = i_data;

        priority if (a < ADDR_SETUP) begin
            o_acc.wr_coef  = wr;
            o_acc.in_range = coef_ok;
        end else if (a < ADDR_PROG) begin
            o_acc.wr_setup = wr;
            o_acc.in_range = setup_ok;
        end else if (a < ADDR_LD_COEF) begin
            o_acc.wr_prog  = wr;
            o_acc.in_range = prog_ok;
        end else if (a < ADDR_LD_ONES) begin
            o_acc.ld_coef  = wr;
            o_acc.in_range = coef_ok;
        end else if (a < ADDR_LD_PROG) begin
            o_acc.ld_ones  = wr;
            o_acc.in_range = 1'b1;
        end else begin
            o_acc.ld_prog  = wr;
            o_acc.in_range = prog_ok;
        end
    end

endmodule

### hw/rtl/hpma_mem.sv
// Coefficient, setup and program memories with byte-lane writes and
// registered reads of coefficient and program words. Depends on hpma_pkg.
module hpma_mem (
    input  logic           i_clk,
    input  logic           i_en,
    input  hpma_pkg::t_acc i_acc,
    output logic [15:0]    o_coef_rdata,
    output logic [31:0]    o_prog_rdata
);
    import hpma_pkg::*;

    logic [15:0] r_coef  [COEF_DEPTH];
    logic [31:0] r_prog  [PROG_DEPTH];
    logic [31:0] r_setup [SETUP_COUNT];

    logic we_coef;
    logic we_prog;
    logic we_setup;

    assign we_coef  = i_en && i_acc.wr_coef  && i_acc.in_range;
    assign we_prog  = i_en && i_acc.wr_prog  && i_acc.in_range;
    assign we_setup = i_en && i_acc.wr_setup && i_acc.in_range;

    // lane 0 is the most significant byte of a 32-bit word
    always_ff @(posedge i_clk) begin
        if (we_coef) begin
            if (i_acc.lane[0]) begin
                r_coef[i_acc.coef_addr][15:8] <= i_acc.data;
            end else begin
                r_coef[i_acc.coef_addr][7:0] <= i_acc.data;
            end
        end
        if (i_en && i_acc.ld_coef) begin
            o_coef_rdata <= r_coef[i_acc.coef_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_prog) begin
            unique case (i_acc.lane)
                2'd0: r_prog[i_acc.prog_addr][31:24] <= i_acc.data;
                2'd1: r_prog[i_acc.prog_addr][23:16] <= i_acc.data;
                2'd2: r_prog[i_acc.prog_addr][15:8]  <= i_acc.data;
                2'd3: r_prog[i_acc.prog_addr][7:0]   <= i_acc.data;
                default: ;
            endcase
        end
        if (i_en && i_acc.ld_prog) begin
            o_prog_rdata <= r_prog[i_acc.prog_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_setup) begin
            unique case (i_acc.lane)
                2'd0: r_setup[i_acc.setup_addr][31:24] <= i_acc.data;
                2'd1: r_setup[i_acc.setup_addr][23:16] <= i_acc.data;
                2'd2: r_setup[i_acc.setup_addr][15:8]  <= i_acc.data;
                2'd3: r_setup[i_acc.setup_addr][7:0]   <= i_acc.data;
                default: ;
            endcase
        end
    end

endmodule

### hw/rtl/dsp_host_port_memory_access.sv
// Top level of the host port: handshakes, read latch and output register.
// Depends on hpma_pkg, hpma_decode and hpma_mem.
//
//  channel   direction  beat contents
//  s_axis    in         tuser: func; tdata: address[13:0], data[21:14]
//  m_axis    out        tdata: read_data[7:0]
//  cfg       in         data: byte_order_reversed
//
// One beat per cycle for memory writes, reads and the all-ones latch load
// while the result register is not held. A latch load from coefficient or
// program memory passes through the synchronous memory read register
// before the latch. Result is registered; s_axis stalls while that register
// is held and while a latch load from memory is pending.
// Synchronous active-low reset clears latch, byte order and valids.
module dsp_host_port_memory_access (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // address[13:0], data[21:14], zero pad
    input  logic        i_s_axis_tuser,  // func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // read_data[7:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    import hpma_pkg::*;

    typedef enum logic [1:0] {
        PEND_COEF = 2'b01,
        PEND_PROG = 2'b10
    } t_pend;

    t_acc        acc;
    logic        s_acc;
    logic [15:0] coef_rdata;
    logic [31:0] prog_rdata;

    logic        r_rev;
    logic [31:0] r_latch, n_latch;
    logic        r_pend;
    t_pend       r_pend_kind;
    logic        r_pend_ok;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_data;

    hpma_decode u_decode (
        .i_rev     (r_rev),
        .i_func    (i_s_axis_tuser),
        .i_address (i_s_axis_tdata[ADDR_W-1:0]),
        .i_data    (i_s_axis_tdata[ADDR_W+7:ADDR_W]),
        .o_acc     (acc)
    );

    hpma_mem u_mem (
        .i_clk        (i_clk),
        .i_en         (s_acc),
        .i_acc        (acc),
        .o_coef_rdata (coef_rdata),
        .o_prog_rdata (prog_rdata)
    );

    assign o_s_axis_tready = !r_pend && (!r_out_valid || i_m_axis_tready);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_comb begin
        n_latch = r_latch;
        if (r_pend) begin
            unique case (r_pend_kind)
                PEND_COEF: n_latch = r_pend_ok ? {16'h0000, coef_rdata} : '0;
                PEND_PROG: n_latch = r_pend_ok ?
                    {8'h00, prog_rdata[15:8], prog_rdata[23:16], prog_rdata[31:24]} : '0;
                default:   n_latch = r_latch;
            endcase
        end else if (s_acc && acc.ld_ones) begin
            n_latch = {4{BYTE_ONES}};
        end

        n_out_valid = r_out_valid;
        if (s_acc) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev       <= 1'b0;
            r_latch     <= '0;
            r_pend      <= 1'b0;
            r_pend_kind <= PEND_COEF;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_rev <= i_cfg_data;
            end
            r_latch     <= n_latch;
            r_out_valid <= n_out_valid;
            r_pend      <= s_acc && (acc.ld_coef || acc.ld_prog);
            if (s_acc && acc.ld_prog) begin
                r_pend_kind <= PEND_PROG;
            end else if (s_acc && acc.ld_coef) begin
                r_pend_kind <= PEND_COEF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_pend_ok  <= acc.in_range;
            r_out_data <= acc.is_read ? r_latch[{acc.lane, 3'b000} +: 8] : 8'h00;
        end
    end

endmodule

### hw/rtl/hpma_checker.sv
// Port-level checks for the host port top level, bound into it.
// Depends on hpma_pkg and dsp_host_port_memory_access.
module hpma_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [23:0] i_s_axis_tdata,
    input logic        i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata
);
    import hpma_pkg::*;

    logic s_beat;
    logic ones_load;

    assign s_beat    = i_s_axis_tvalid && o_s_axis_tready;
    assign ones_load = s_beat && (i_s_axis_tuser == FUNC_WRITE)
                       && (i_s_axis_tdata[13:11] == 3'b101);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat |=> o_m_axis_tvalid)
        else $error("accepted beat gave no result");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat && (i_s_axis_tuser == FUNC_WRITE) |=> (o_m_axis_tdata == 8'h00))
        else $error("write beat result not zero");

    a_ones_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ones_load ##1 (s_beat && (i_s_axis_tuser == FUNC_READ))
        |=> (o_m_axis_tdata == BYTE_ONES))
        else $error("read after all-ones load not 0xFF");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind dsp_host_port_memory_access hpma_checker u_hpma_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

### sim/dsp_host_port_memory_access_test.sv
// Self-checking bench for the host port: byte writes to coefficient, setup and program
// memories, read latch loads and latch reads, in both byte orders, with random stalls.
// Depends on hpma_pkg and dsp_host_port_memory_access.
module dsp_host_port_memory_access_test;
    import hpma_pkg::*;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] address;
        logic [7:0]        data;
    } t_host_access;

    localparam logic [1:0] LANE_FLIP = 2'b11;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;

    // predicted block state
    logic [15:0] coef_words [COEF_DEPTH];
    logic [31:0] prog_words [PROG_DEPTH];
    logic [31:0] setup_regs [SETUP_COUNT];
    logic [1:0]  coef_filled [COEF_DEPTH];
    logic [3:0]  prog_filled [PROG_DEPTH];
    logic [7:0]  latch_bytes [4];
    logic        order_rev = 1'b0;

    int          coef_loadable[$];
    int          prog_loadable[$];
    logic [7:0]  read_bytes_due[$];
    logic [7:0]  due_byte;
    int          mismatch_count = 0;
    int          sent_count = 0;
    bit          tx_gaps_on = 1'b1;
    bit          rx_gaps_on = 1'b1;
    logic        hold_rx = 1'b0;

    dsp_host_port_memory_access u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Applies one access to the predicted state and returns the byte it should produce.
    function automatic logic [7:0] predict_host_access(input t_host_access acc);
        logic [ADDR_W-1:0] a;
        logic [1:0]        lane;
        int                idx;
        logic [31:0]       w;
        a = acc.address;
        if (order_rev) begin
            a[1:0] = a[1:0] ^ LANE_FLIP;
        end
        lane = a[1:0];
        if (acc.func == FUNC_READ) begin
            return latch_bytes[lane];
        end
        if (a < ADDR_SETUP) begin
            idx = int'(a) >> 1;
            if (idx < COEF_DEPTH) begin
                if (a[0]) begin
                    coef_words[idx][15:8] = acc.data;
                end else begin
                    coef_words[idx][7:0] = acc.data;
                end
                if (coef_filled[idx] != 2'b11) begin
                    coef_filled[idx][a[0]] = 1'b1;
                    if (coef_filled[idx] == 2'b11) begin
                        coef_loadable.push_back(idx);
                    end
                end
            end
        end else if (a < ADDR_PROG) begin
            idx = ((int'(a) - int'(ADDR_SETUP)) >> 2) & 15;
            if (idx < SETUP_COUNT) begin
                setup_regs[idx][8 * (3 - int'(lane)) +: 8] = acc.data;
            end
        end else if (a < ADDR_LD_COEF) begin
            idx = ((int'(a) - int'(ADDR_PROG)) >> 2) & 1023;
            if (idx < PROG_DEPTH) begin
                prog_words[idx][8 * (3 - int'(lane)) +: 8] = acc.data;
                if (prog_filled[idx] != 4'hF) begin
                    prog_filled[idx][lane] = 1'b1;
                    if (prog_filled[idx] == 4'hF) begin
                        prog_loadable.push_back(idx);
                    end
                end
            end
        end else if (a < ADDR_LD_ONES) begin
            idx = ((int'(a) - int'(ADDR_LD_COEF)) >> 1) & 1023;
            w = (idx < COEF_DEPTH) ? {16'h0000, coef_words[idx]} : '0;
            latch_bytes[0] = w[7:0];
            latch_bytes[1] = w[15:8];
            latch_bytes[2] = 8'h00;
            latch_bytes[3] = 8'h00;
        end else if (a < ADDR_LD_PROG) begin
            for (int k = 0; k < 4; k++) begin
                latch_bytes[k] = BYTE_ONES;
            end
        end else begin
            idx = ((int'(a) - int'(ADDR_LD_PROG)) >> 2) & 1023;
            w = (idx < PROG_DEPTH) ? prog_words[idx] : '0;
            latch_bytes[0] = w[31:24];
            latch_bytes[1] = w[23:16];
            latch_bytes[2] = w[15:8];
            latch_bytes[3] = 8'h00;
        end
        return 8'h00;
    endfunction

    // Address given as decoded; the lane bits are flipped on the wire in reversed mode.
    task automatic send_access(input logic func, input logic [ADDR_W-1:0] decoded,
                               input logic [7:0] data);
        t_host_access acc;
        acc.func = func;
        acc.address = decoded ^ {{(ADDR_W-2){1'b0}}, order_rev ? LANE_FLIP : 2'b00};
        acc.data = data;
        while (tx_gaps_on && $urandom_range(99) < 38) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, acc.data, acc.address};
        i_s_axis_tuser  <= acc.func;
        do @(posedge i_clk); while (!o_s_axis_tready);
        read_bytes_due.push_back(predict_host_access(acc));
        sent_count++;
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (read_bytes_due.size() != 0);
    endtask

    task automatic set_byte_order(input logic rev);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= rev;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        order_rev = rev;
    endtask

    // Result side: check each beat, then choose tready for the next edge.
    always @(posedge i_clk) begin
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (read_bytes_due.size() == 0) begin
                report_mismatch($sformatf("result beat %02h with nothing expected",
                                          o_m_axis_tdata));
            end else begin
                due_byte = read_bytes_due.pop_front();
                if (o_m_axis_tdata !== due_byte) begin
                    report_mismatch($sformatf("read_data %02h, expected %02h",
                                              o_m_axis_tdata, due_byte));
                end
            end
        end
        if (!i_rst_n || hold_rx) begin
            i_m_axis_tready <= 1'b0;
        end else if (rx_gaps_on) begin
            i_m_axis_tready <= ($urandom_range(99) >= 38);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    task automatic run_mixed_traffic(input int n);
        int target;
        int pick;
        int idx;
        int first;
        target = sent_count + n;
        while (sent_count < target) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                // coefficient word filled, loaded and read back
                idx = $urandom_range(COEF_DEPTH - 1);
                first = $urandom_range(1);
                send_access(FUNC_WRITE, 14'(idx * 2 + first), 8'($urandom));
                send_access(FUNC_WRITE, 14'(idx * 2 + 1 - first), 8'($urandom));
                send_access(FUNC_WRITE, ADDR_LD_COEF + 14'(idx * 2 + $urandom_range(1)),
                            8'($urandom));
                repeat ($urandom_range(1, 4)) send_access(FUNC_READ, 14'($urandom), 8'($urandom));
            end else if (pick < 50) begin
                idx = $urandom_range(PROG_DEPTH - 1);
                first = $urandom_range(3);
                for (int k = 0; k < 4; k++) begin
                    send_access(FUNC_WRITE, ADDR_PROG + 14'(idx * 4 + ((first + k) & 3)),
                                8'($urandom));
                end
                send_access(FUNC_WRITE, ADDR_LD_PROG + 14'(idx * 4 + $urandom_range(3)),
                            8'($urandom));
                repeat ($urandom_range(1, 4)) send_access(FUNC_READ, 14'($urandom), 8'($urandom));
            end else if (pick < 68) begin
                send_access(FUNC_WRITE, 14'($urandom_range(16'h1FFF)), 8'($urandom));
            end else if (pick < 76 && coef_loadable.size() != 0) begin
                idx = coef_loadable[$urandom_range(coef_loadable.size() - 1)];
                send_access(FUNC_WRITE, ADDR_LD_COEF + 14'(idx * 2 + $urandom_range(1)),
                            8'($urandom));
            end else if (pick < 84 && prog_loadable.size() != 0) begin
                idx = prog_loadable[$urandom_range(prog_loadable.size() - 1)];
                send_access(FUNC_WRITE, ADDR_LD_PROG + 14'(idx * 4 + $urandom_range(3)),
                            8'($urandom));
            end else if (pick < 88) begin
                send_access(FUNC_WRITE, ADDR_LD_ONES + 14'($urandom_range(2047)), 8'($urandom));
            end else begin
                send_access(FUNC_READ, 14'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic test_reset_latch();
        set_byte_order(1'b0);
        send_access(FUNC_READ, 14'h0000, 8'h00);
        send_access(FUNC_READ, 14'h3FFF, 8'hFF);
        drain_results();
    endtask

    task automatic test_regions_normal_order();
        set_byte_order(1'b0);
        send_access(FUNC_WRITE, 14'h0000, 8'hA5);
        send_access(FUNC_WRITE, 14'h0001, 8'hFF);
        send_access(FUNC_WRITE, ADDR_SETUP, 8'h12);
        send_access(FUNC_WRITE, 14'h0FFF, 8'h34);
        send_access(FUNC_WRITE, 14'h1FFC, 8'h11);
        send_access(FUNC_WRITE, 14'h1FFD, 8'h22);
        send_access(FUNC_WRITE, 14'h1FFE, 8'h33);
        send_access(FUNC_WRITE, 14'h1FFF, 8'h00);
        send_access(FUNC_WRITE, ADDR_LD_COEF, 8'h00);
        send_access(FUNC_READ, 14'h0001, 8'h00);
        send_access(FUNC_READ, 14'h0002, 8'h00);
        send_access(FUNC_WRITE, 14'h3FFF, 8'hFF);
        for (int l = 0; l < 4; l++) begin
            send_access(FUNC_READ, 14'(l), 8'h00);
        end
        send_access(FUNC_WRITE, 14'h2FFF, 8'h00);
        send_access(FUNC_READ, 14'h0002, 8'hFF);
        drain_results();
    endtask

    task automatic test_regions_reversed_order();
        set_byte_order(1'b1);
        send_access(FUNC_WRITE, 14'h07FE, 8'h5A);
        send_access(FUNC_WRITE, 14'h07FF, 8'hC3);
        send_access(FUNC_WRITE, 14'h0FFF, 8'h96);
        send_access(FUNC_WRITE, 14'h27FF, 8'h00);
        send_access(FUNC_READ, 14'h0000, 8'h00);
        send_access(FUNC_READ, 14'h0001, 8'h00);
        send_access(FUNC_WRITE, ADDR_LD_ONES, 8'h00);
        send_access(FUNC_READ, 14'h0003, 8'h00);
        drain_results();
    endtask

    task automatic test_random_traffic(input logic rev, input int n);
        set_byte_order(rev);
        run_mixed_traffic(n);
        drain_results();
    endtask

    // Receiver holds off long enough for the result register to fill and stall input.
    task automatic test_output_backpressure();
        set_byte_order(1'b1);
        tx_gaps_on = 1'b0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
        join_none
        run_mixed_traffic(150);
        drain_results();
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        set_byte_order(1'b0);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        run_mixed_traffic(300);
        drain_results();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    initial begin
        for (int k = 0; k < 4; k++) begin
            latch_bytes[k] = 8'h00;
        end
        for (int k = 0; k < COEF_DEPTH; k++) begin
            coef_words[k] = '0;
            coef_filled[k] = '0;
        end
        for (int k = 0; k < PROG_DEPTH; k++) begin
            prog_words[k] = '0;
            prog_filled[k] = '0;
        end
        for (int k = 0; k < SETUP_COUNT; k++) begin
            setup_regs[k] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_latch();
        test_regions_normal_order();
        test_regions_reversed_order();
        test_random_traffic(1'b0, 500);
        test_random_traffic(1'b1, 500);
        test_output_backpressure();
        test_back_to_back();
        test_random_traffic(1'b1, 470);

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
